/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ict_pkg.sv */
// ---------------------------------------------------------------------------
// ict_pkg
// Types, codes and arithmetic helpers of the interval cycle timer.
// ---------------------------------------------------------------------------
package ict_pkg;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;

	localparam logic [1:0] REG_FOCUS  = 2'd0;
	localparam logic [1:0] REG_REST   = 2'd1;
	localparam logic [1:0] REG_TARGET = 2'd2;

	localparam logic [2:0] EV_START_ACK = 3'd0;
	localparam logic [2:0] EV_STOP_ACK  = 3'd1;
	localparam logic [2:0] EV_STARTED   = 3'd2;
	localparam logic [2:0] EV_PHASE     = 3'd3;
	localparam logic [2:0] EV_UPDATE    = 3'd4;
	localparam logic [2:0] EV_DONE      = 3'd5;

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_MIDDLE = 2'd1;
	localparam logic [1:0] PH_LATE   = 2'd2;

	// which state snapshot a queued result reports
	localparam logic [1:0] SRC_NEW  = 2'd0;
	localparam logic [1:0] SRC_OLD  = 2'd1;
	localparam logic [1:0] SRC_ACK  = 2'd2;
	localparam logic [1:0] SRC_DONE = 2'd3;

	// 2^20 / 60 rounded up; exact quotient for any 14-bit dividend
	localparam logic [14:0] RECIP60 = 15'd17477;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] phase;
		logic [1:0] src;
	} slot_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        rest_mode;
		logic [1:0]  phase;
		logic [7:0]  cycle_number;
		logic [13:0] remaining_seconds;
		logic [13:0] total_seconds;
		logic [7:0]  minutes_left;
		logic [5:0]  seconds_left;
	} res_t;

	typedef struct packed {
		logic [7:0] minutes;
		logic [5:0] seconds;
	} mmss_t;

	function automatic logic [13:0] mul60(logic [7:0] m);
		return 14'({m, 6'b0}) - 14'({m, 2'b0});
	endfunction

	function automatic mmss_t div60(logic [13:0] x);
		logic [28:0] p;
		logic [8:0]  q;
		logic [13:0] qx60;
		mmss_t       r;
		p         = 29'(x) * 29'(RECIP60);
		q         = p[28:20];
		qx60      = 14'({q, 6'b0}) - 14'({q, 2'b0});
		r.minutes = q[7:0];
		r.seconds = 6'(x - qx60);
		return r;
	endfunction

endpackage

/* hdl/interval_cycle_timer.sv */
// ---------------------------------------------------------------------------
// interval_cycle_timer
// Two-interval repeating countdown timer with phase and completion events.
// ---------------------------------------------------------------------------
// channel  | dir | tdata                        | tuser       | tlast
// s_axis   | in  | seconds_passed[7:0]          | func[1:0]   | -
// m_axis   | out | rest/phase/cycle/rem/tot/m/s | event_kind  | last of item
// cfg      | in  | cfg_wr_en, cfg_addr[1:0], cfg_wdata[7:0]
//
// An accepted transaction is held in the input register, then its
// 0..4 results are built in one pass and loaded into a result buffer.
// The buffer drains one result per cycle while m_tready is high, so the
// buffer drain sets the sustained rate.
// A new input is taken while the last result of the previous item leaves.
// Reset is asynchronous, active low; all timer state returns to idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module interval_cycle_timer
	import ict_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // seconds_passed[7:0]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// rest_mode[0], phase[2:1], cycle_number[10:3], remaining_seconds[24:11],
	// total_seconds[38:25], minutes_left[46:39], seconds_left[52:47], zero[55:53]
	output logic [55:0] m_tdata,
	output logic [2:0]  m_tuser,   // event_kind[2:0]
	output logic        m_tlast
);

	logic [7:0]  focus_q, rest_q, target_q;
	logic        running_q, pending_q, in_rest_q;
	logic [7:0]  cycle_q;
	logic [13:0] rem_q, total_q;
	logic        start_rep_q, mid_rep_q, late_rep_q;

	logic        vld_s1;
	logic [1:0]  func_s1;
	logic [7:0]  secs_s1;

	logic        vld_s2;
	logic [2:0]  cnt_s2;
	logic [1:0]  idx_q;
	res_t        res_s2 [4];

	logic        bundle_free, commit;

	logic        nx_running, nx_pending, nx_in_rest;
	logic [7:0]  nx_cycle;
	logic [13:0] nx_rem, nx_total;
	logic        nx_start_rep, nx_mid_rep, nx_late_rep;
	slot_t       slot [4];
	logic [2:0]  cnt;
	res_t        res [4];

	always_comb begin
		logic        begin_iv;
		logic        begin_rest;
		mmss_t       mo;
		mmss_t       mn;
		nx_running   = running_q;
		nx_pending   = pending_q;
		nx_in_rest   = in_rest_q;
		nx_cycle     = cycle_q;
		nx_rem       = rem_q;
		nx_total     = total_q;
		nx_start_rep = start_rep_q;
		nx_mid_rep   = mid_rep_q;
		nx_late_rep  = late_rep_q;
		begin_iv     = 1'b0;
		begin_rest   = 1'b0;
		cnt          = '0;
		for (int i = 0; i < 4; i++) begin
			slot[i] = '0;
		end

		unique case (func_s1)
			FUNC_START: begin
				nx_cycle   = 8'd1;
				nx_pending = 1'b1;
				nx_running = 1'b0;
				slot[cnt[1:0]] = '{kind: EV_START_ACK, phase: PH_START, src: SRC_ACK};
				cnt = cnt + 3'd1;
			end
			FUNC_STOP: begin
				nx_running = 1'b0;
				nx_pending = 1'b0;
				slot[cnt[1:0]] = '{kind: EV_STOP_ACK, phase: PH_START, src: SRC_ACK};
				cnt = cnt + 3'd1;
			end
			FUNC_TICK: begin
				if (pending_q) begin
					nx_pending = 1'b0;
					nx_running = 1'b1;
					nx_cycle   = 8'd1;
					begin_iv   = 1'b1;
				end else if (running_q) begin
					if (!start_rep_q) begin
						slot[cnt[1:0]] = '{kind: EV_PHASE, phase: PH_START, src: SRC_OLD};
						cnt = cnt + 3'd1;
						nx_start_rep = 1'b1;
					end
					if (secs_s1 != 8'd0) begin
						if (rem_q != 14'd0) begin
							nx_rem = (rem_q >= 14'(secs_s1)) ? rem_q - 14'(secs_s1) : 14'd0;
							slot[cnt[1:0]] = '{kind: EV_UPDATE, phase: PH_START, src: SRC_NEW};
							cnt = cnt + 3'd1;
							if (!in_rest_q && !mid_rep_q &&
							    ({nx_rem, 1'b0} <= {1'b0, total_q})) begin
								slot[cnt[1:0]] = '{kind: EV_PHASE, phase: PH_MIDDLE, src: SRC_NEW};
								cnt = cnt + 3'd1;
								nx_mid_rep = 1'b1;
							end
							if (!late_rep_q &&
							    ((18'(nx_rem) << 3) + (18'(nx_rem) << 1) <= 18'(total_q))) begin
								slot[cnt[1:0]] = '{kind: EV_PHASE, phase: PH_LATE, src: SRC_NEW};
								cnt = cnt + 3'd1;
								nx_late_rep = 1'b1;
							end
						end else if (!in_rest_q) begin
							if (cycle_q >= target_q) begin
								nx_running = 1'b0;
								slot[cnt[1:0]] = '{kind: EV_DONE, phase: PH_START, src: SRC_DONE};
								cnt = cnt + 3'd1;
							end else begin
								begin_iv   = 1'b1;
								begin_rest = 1'b1;
							end
						end else begin
							if (cycle_q != 8'd255) begin
								nx_cycle = cycle_q + 8'd1;
							end
							begin_iv = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (begin_iv) begin
			nx_in_rest   = begin_rest;
			nx_total     = mul60(begin_rest ? rest_q : focus_q);
			nx_rem       = nx_total;
			nx_mid_rep   = 1'b0;
			nx_late_rep  = 1'b0;
			nx_start_rep = 1'b1;
			slot[cnt[1:0]] = '{kind: EV_STARTED, phase: PH_START, src: SRC_NEW};
			cnt = cnt + 3'd1;
			slot[cnt[1:0]] = '{kind: EV_PHASE, phase: PH_START, src: SRC_NEW};
			cnt = cnt + 3'd1;
		end

		mo = div60(rem_q);
		mn = div60(nx_rem);
		for (int i = 0; i < 4; i++) begin
			res[i] = '0;
			res[i].kind = slot[i].kind;
			unique case (slot[i].src)
				SRC_OLD: begin
					res[i].rest_mode         = in_rest_q;
					res[i].phase             = slot[i].phase;
					res[i].cycle_number      = cycle_q;
					res[i].remaining_seconds = rem_q;
					res[i].total_seconds     = total_q;
					res[i].minutes_left      = mo.minutes;
					res[i].seconds_left      = mo.seconds;
				end
				SRC_NEW, SRC_DONE: begin
					res[i].rest_mode         = nx_in_rest;
					res[i].phase             = slot[i].phase;
					res[i].cycle_number      = (slot[i].src == SRC_DONE) ? target_q : nx_cycle;
					res[i].remaining_seconds = nx_rem;
					res[i].total_seconds     = nx_total;
					res[i].minutes_left      = mn.minutes;
					res[i].seconds_left      = mn.seconds;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid    = vld_s2;
	assign m_tlast     = ({1'b0, idx_q} == (cnt_s2 - 3'd1));
	assign bundle_free = !vld_s2 || (m_tready && m_tlast);
	assign commit      = vld_s1 && bundle_free;
	assign s_tready    = !vld_s1 || bundle_free;

	always_comb begin
		res_t r;
		r       = res_s2[idx_q];
		m_tuser = r.kind;
		m_tdata = {3'b0, r.seconds_left, r.minutes_left, r.total_seconds,
		           r.remaining_seconds, r.cycle_number, r.phase, r.rest_mode};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_q     <= 8'd25;
			rest_q      <= 8'd5;
			target_q    <= 8'd1;
			running_q   <= 1'b0;
			pending_q   <= 1'b0;
			in_rest_q   <= 1'b0;
			cycle_q     <= 8'd1;
			rem_q       <= '0;
			total_q     <= '0;
			start_rep_q <= 1'b0;
			mid_rep_q   <= 1'b0;
			late_rep_q  <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			cnt_s2      <= '0;
			idx_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					REG_FOCUS:  focus_q  <= cfg_wdata;
					REG_REST:   rest_q   <= cfg_wdata;
					REG_TARGET: target_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				vld_s1 <= 1'b1;
			end else if (commit) begin
				vld_s1 <= 1'b0;
			end
			if (commit) begin
				running_q   <= nx_running;
				pending_q   <= nx_pending;
				in_rest_q   <= nx_in_rest;
				cycle_q     <= nx_cycle;
				rem_q       <= nx_rem;
				total_q     <= nx_total;
				start_rep_q <= nx_start_rep;
				mid_rep_q   <= nx_mid_rep;
				late_rep_q  <= nx_late_rep;
			end
			if (commit && cnt != 3'd0) begin
				vld_s2 <= 1'b1;
				cnt_s2 <= cnt;
				idx_q  <= '0;
			end else if (m_tvalid && m_tready) begin
				if (m_tlast) begin
					vld_s2 <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			secs_s1 <= s_tdata;
		end
		if (commit && cnt != 3'd0) begin
			res_s2 <= res;
		end
	end

	`ASSERT_SAME(a_buf_count, m_tvalid, (cnt_s2 != 3'd0) && ({1'b0, idx_q} < cnt_s2), "result index out of range")
	`ASSERT_ALWAYS(a_run_pend, !(running_q && pending_q), "running and start pending together")
	`ASSERT_ALWAYS(a_rem_le_total, rem_q <= total_q, "remaining exceeds interval total")
	`ASSERT_NEXT(a_start_cycle, commit && (func_s1 == FUNC_START), (cycle_q == 8'd1) && pending_q, "start did not rearm")

endmodule
